// ----- hw/rtl/pmq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmq_pkg: shared types and constants of the priority message queue
// Request and response layouts, operation and status codes, and the sizes
// of the queue storage.
// ----------------------------------------------------------------------------
package pmq_pkg;

    // Queue sizing.
    localparam int QUEUE_DEPTH       = 16;
    localparam int MAX_MESSAGE_BYTES = 8;
    localparam int IDX_W             = $clog2(QUEUE_DEPTH);
    localparam int CNT_W             = $clog2(QUEUE_DEPTH + 1);

    // Field widths fixed by the interface.
    localparam int KIND_W    = 2;
    localparam int PRIO_W    = 8;
    localparam int PAYLOAD_W = 64;
    localparam int STATUS_W  = 2;
    localparam int LEN_W     = 4;
    localparam int OCC_W     = 5;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_MESSAGE_BYTES = 3'd0;
    localparam logic [LEN_W-1:0]      MESSAGE_BYTES_RESET = 4'd8;

    // Operation codes.
    localparam logic [KIND_W-1:0] KIND_SEND    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RECEIVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH   = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [PRIO_W-1:0]    priority_req;
        logic [PAYLOAD_W-1:0] payload;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [PAYLOAD_W-1:0] data;
        logic [LEN_W-1:0]     length;
        logic [OCC_W-1:0]     occupancy;
    } rsp_t;

    // One stored message.
    typedef struct packed {
        logic [PRIO_W-1:0]    prio;
        logic [LEN_W-1:0]     len;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

endpackage

// ----- hw/rtl/priority_message_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_message_queue: bounded message queue in descending priority order
// Messages live in a ring buffer held in one synchronous RAM. A send walks
// from the tail toward the head, moving lower-priority entries up by one
// slot, and drops the new message into the gap. A receive pops the head.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  req       in         req_valid/req_stall   req_t: kind, priority_req, payload
//  rsp       out        rsp_valid/rsp_stall   rsp_t: status, data, length, occupancy
//  config    in         APB (psel/penable)    message_bytes at byte address 0
//
// One request at a time. A send into a non-empty queue walks from the tail
// toward the head, one RAM read per compared entry through the single read
// port, before its response is loaded. A receive reads the head entry; a
// send into an empty queue, a flush or a refused request needs no RAM read.
// The response register lets a new request enter while the previous
// response is still stalled; a result that finds it still occupied waits,
// with the request side stalled, for as long as the response stalls.
// After reset the queue is empty and message_bytes is 8; the RAM needs no
// clearing.
//
module priority_message_queue
    import pmq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Request channel.
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req,
    // Response channel.
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_INSERT = 3'd2;
    localparam logic [2:0] S_RECV   = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    // Ring index helpers.
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(QUEUE_DEPTH - 1) : i - IDX_W'(1);
    endfunction

    // Bytes kept per message, clamped into the supported range.
    function automatic logic [LEN_W-1:0] eff_bytes(input logic [LEN_W-1:0] n);
        logic [LEN_W-1:0] r;
        r = n;
        if (r == '0)
            r = LEN_W'(1);
        if (r > LEN_W'(MAX_MESSAGE_BYTES))
            r = LEN_W'(MAX_MESSAGE_BYTES);
        return r;
    endfunction

    function automatic logic [PAYLOAD_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [PAYLOAD_W-1:0] m;
        m = '0;
        for (int b = 0; b < PAYLOAD_W / 8; b++)
        begin
            if (LEN_W'(b) < n)
                m[8*b +: 8] = 8'hFF;
        end
        return m;
    endfunction

    // Registers.
    logic [2:0]        state_reg,  state_next;
    logic [IDX_W-1:0]  head_reg,   head_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [IDX_W-1:0]  ptr_reg,    ptr_next;
    logic [IDX_W-1:0]  hole_reg,   hole_next;
    logic [IDX_W-1:0]  left_reg,   left_next;
    entry_t            new_reg,    new_next;
    rsp_t              res_reg,    res_next;
    rsp_t              out_reg,    out_next;
    logic              out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]  msg_bytes_reg;

    // Queue RAM.
    entry_t            mem [QUEUE_DEPTH];
    entry_t            rdata_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic [IDX_W-1:0]  rd_addr;

    logic              req_accept;
    logic              out_free;
    logic [CNT_W:0]    tail_sum;
    logic [IDX_W-1:0]  tail;
    logic [LEN_W-1:0]  n_bytes;

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign out_free   = !out_valid_reg || !rsp_stall;
    assign rsp_valid  = out_valid_reg;
    assign rsp        = out_reg;

    // Tail slot: head plus count, wrapped once.
    assign tail_sum = (CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg);
    assign tail = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH))
                ? IDX_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH))
                : IDX_W'(tail_sum);
    assign n_bytes = eff_bytes(msg_bytes_reg);

    // Configuration register and read-back.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MESSAGE_BYTES)
                  ? APB_DATA_W'(msg_bytes_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            msg_bytes_reg <= MESSAGE_BYTES_RESET;
        else if (psel && penable && pwrite && pready && paddr == ADDR_MESSAGE_BYTES)
            msg_bytes_reg <= pwdata[LEN_W-1:0];
    end

    // Queue RAM: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        hole_next      = hole_reg;
        left_next      = left_reg;
        new_next       = new_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        wr_en          = 1'b0;
        wr_addr        = hole_reg;
        wr_data        = new_reg;
        rd_addr        = ptr_reg;

        // A taken response frees the output register.
        if (out_valid_reg && !rsp_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    res_next.status    = STATUS_DONE;
                    res_next.data      = '0;
                    res_next.length    = '0;
                    res_next.occupancy = OCC_W'(count_reg);
                    state_next         = S_OUT;
                    unique case (req.kind)
                        KIND_SEND:
                        begin
                            new_next.prio    = req.priority_req;
                            new_next.len     = n_bytes;
                            new_next.payload = req.payload & byte_mask(n_bytes);
                            if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                res_next.status = STATUS_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                // Empty queue: store straight at the tail.
                                wr_en              = 1'b1;
                                wr_addr            = tail;
                                wr_data            = new_next;
                                count_next         = CNT_W'(1);
                                res_next.length    = n_bytes;
                                res_next.occupancy = OCC_W'(1);
                            end
                            else
                            begin
                                // Start the walk at the last stored entry.
                                hole_next  = tail;
                                ptr_next   = idx_dec(tail);
                                rd_addr    = idx_dec(tail);
                                left_next  = IDX_W'(count_reg - CNT_W'(1));
                                state_next = S_SCAN;
                            end
                        end
                        KIND_RECEIVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_addr    = head_reg;
                                state_next = S_RECV;
                            end
                        end
                        KIND_FLUSH:
                        begin
                            count_next         = '0;
                            res_next.occupancy = '0;
                        end
                        default:
                        begin
                            // Unused code: the queue is left unchanged.
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (rdata_reg.prio < new_reg.prio)
                begin
                    // Lower priority: move it up into the hole.
                    wr_en     = 1'b1;
                    wr_addr   = hole_reg;
                    wr_data   = rdata_reg;
                    hole_next = ptr_reg;
                    if (left_reg == '0)
                    begin
                        state_next = S_INSERT;
                    end
                    else
                    begin
                        ptr_next  = idx_dec(ptr_reg);
                        rd_addr   = idx_dec(ptr_reg);
                        left_next = left_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    // Equal or higher priority stays ahead of the new message.
                    wr_en              = 1'b1;
                    wr_addr            = hole_reg;
                    wr_data            = new_reg;
                    count_next         = count_reg + CNT_W'(1);
                    res_next.length    = new_reg.len;
                    res_next.occupancy = OCC_W'(count_reg + CNT_W'(1));
                    state_next         = S_OUT;
                end
            end

            S_INSERT:
            begin
                wr_en              = 1'b1;
                wr_addr            = hole_reg;
                wr_data            = new_reg;
                count_next         = count_reg + CNT_W'(1);
                res_next.length    = new_reg.len;
                res_next.occupancy = OCC_W'(count_reg + CNT_W'(1));
                state_next         = S_OUT;
            end

            S_RECV:
            begin
                res_next.data      = rdata_reg.payload;
                res_next.length    = rdata_reg.len;
                res_next.occupancy = OCC_W'(count_reg - CNT_W'(1));
                head_next          = idx_inc(head_reg);
                count_next         = count_reg - CNT_W'(1);
                state_next         = S_OUT;
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        hole_reg <= hole_next;
        left_reg <= left_next;
        new_reg  <= new_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

endmodule
